[src/sdff_pkg.sv]
package sdff_pkg;

  localparam int VALUE_W    = 32;
  localparam int WIDTH_W    = 6;
  localparam int PREC_W     = 7;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int ND_W       = $clog2(NUM_DIGITS + 1);
  localparam int BIT_CNT_W  = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

  localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_ADJ     = 4'd3;

  typedef enum logic [1:0] {
    SEL_SPACE,
    SEL_SIGN,
    SEL_DIGIT
  } char_sel_t;

  typedef enum logic {
    CNT_PAD,
    CNT_LEN
  } cnt_sel_t;

  typedef struct packed {
    logic      load;
    logic      conv;
    logic      size;
    logic      cnt_load;
    cnt_sel_t  cnt_sel;
    logic      cnt_dec;
    logic      push;
    char_sel_t char_sel;
    logic      last;
  } sdff_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic cnt_one;
    logic lpad_en;
    logic sign_en;
    logic body_en;
    logic rpad_en;
    logic out_free;
  } sdff_sts_t;

endpackage

[src/sdff_num_if.sv]
interface sdff_num_if import sdff_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic [WIDTH_W-1:0]        width;
  logic signed [PREC_W-1:0]  precision;
  logic                      flag_minus;
  logic                      flag_zero;
  logic                      flag_plus;
  logic                      flag_space;

  modport source (
    output valid, value, width, precision, flag_minus, flag_zero, flag_plus, flag_space,
    input  ready
  );

  modport sink (
    input  valid, value, width, precision, flag_minus, flag_zero, flag_plus, flag_space,
    output ready
  );
endinterface

[src/sdff_text_if.sv]
interface sdff_text_if import sdff_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] text_char;
  logic              last;

  modport source (
    output valid, text_char, last,
    input  ready
  );

  modport sink (
    input  valid, text_char, last,
    output ready
  );
endinterface

[src/sdff_ctrl.sv]
module sdff_ctrl import sdff_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  sdff_sts_t sts,
  output sdff_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CONV  = 8'b0000_0010,
    S_SIZE  = 8'b0000_0100,
    S_START = 8'b0000_1000,
    S_LPAD  = 8'b0001_0000,
    S_SIGN  = 8'b0010_0000,
    S_BODY  = 8'b0100_0000,
    S_RPAD  = 8'b1000_0000
  } state_t;

  state_t     state;
  state_t     state_next;
  state_t     goto;
  logic [3:0] en;
  logic [3:0] mask;
  logic       advance;

  function automatic state_t pick_phase(input logic [3:0] sel);
    state_t nxt;
    priority if (sel[0]) begin
      nxt = S_LPAD;
    end else if (sel[1]) begin
      nxt = S_SIGN;
    end else if (sel[2]) begin
      nxt = S_BODY;
    end else if (sel[3]) begin
      nxt = S_RPAD;
    end else begin
      nxt = S_IDLE;
    end
    return nxt;
  endfunction

  assign en = {sts.rpad_en, sts.body_en, sts.sign_en, sts.lpad_en};

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    mask       = 4'b0000;
    advance    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv = 1'b1;
        if (sts.conv_done) begin
          state_next = S_SIZE;
        end
      end
      S_SIZE: begin
        cmd.size   = 1'b1;
        state_next = S_START;
      end
      S_START: begin
        mask    = 4'b1111;
        advance = 1'b1;
      end
      S_LPAD: begin
        if (sts.out_free) begin
          cmd.push     = 1'b1;
          cmd.char_sel = SEL_SPACE;
          cmd.cnt_dec  = 1'b1;
          mask         = 4'b1110;
          advance      = sts.cnt_one;
        end
      end
      S_SIGN: begin
        if (sts.out_free) begin
          cmd.push     = 1'b1;
          cmd.char_sel = SEL_SIGN;
          mask         = 4'b1100;
          advance      = 1'b1;
        end
      end
      S_BODY: begin
        if (sts.out_free) begin
          cmd.push     = 1'b1;
          cmd.char_sel = SEL_DIGIT;
          cmd.cnt_dec  = 1'b1;
          mask         = 4'b1000;
          advance      = sts.cnt_one;
        end
      end
      S_RPAD: begin
        if (sts.out_free) begin
          cmd.push     = 1'b1;
          cmd.char_sel = SEL_SPACE;
          cmd.cnt_dec  = 1'b1;
          mask         = 4'b0000;
          advance      = sts.cnt_one;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    goto = pick_phase(en & mask);
    if (advance) begin
      state_next   = goto;
      cmd.cnt_load = (goto == S_LPAD) || (goto == S_RPAD) || (goto == S_BODY);
      cmd.cnt_sel  = (goto == S_BODY) ? CNT_LEN : CNT_PAD;
      cmd.last     = cmd.push && (goto == S_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[src/sdff_dp.sv]
module sdff_dp import sdff_pkg::*; #(
  parameter int MAX_FIELD = 63
) (
  input  logic                      clk,
  input  logic                      rst,
  input  sdff_cmd_t                 cmd,
  output sdff_sts_t                 sts,
  input  logic signed [VALUE_W-1:0] value,
  input  logic [WIDTH_W-1:0]        width,
  input  logic signed [PREC_W-1:0]  precision,
  input  logic                      flag_minus,
  input  logic                      flag_zero,
  input  logic                      flag_plus,
  input  logic                      flag_space,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [CHAR_W-1:0]         text_char,
  output logic                      last
);

  localparam int CW = $clog2(MAX_FIELD + 2);

  logic [VALUE_W-1:0]            mag;
  logic [NUM_DIGITS*DIGIT_W-1:0] bcd;
  logic [NUM_DIGITS*DIGIT_W-1:0] bcd_adj;
  logic [BIT_CNT_W-1:0]          bit_cnt;
  logic                          neg;
  logic                          fminus;
  logic                          fzero;
  logic                          fplus;
  logic                          fspace;
  logic                          has_prec;
  logic [CW-1:0]                 width_s;
  logic [CW-1:0]                 prec_s;
  logic [CW-1:0]                 width_sat;
  logic [CW-1:0]                 prec_sat;
  logic [CW-1:0]                 len;
  logic [CW-1:0]                 pad;
  logic [CW-1:0]                 cnt;
  logic [ND_W-1:0]               nd;
  logic [ND_W-1:0]               hi;
  logic [ND_W-1:0]               nd_c;
  logic [CW-1:0]                 len_c;
  logic [CW-1:0]                 body_c;
  logic [CW-1:0]                 pad_c;
  logic                          add;
  logic [CW-1:0]                 pos;
  logic [DIGIT_W-1:0]            digit;
  logic [CHAR_W-1:0]             char_c;
  logic [CHAR_W-1:0]             sign_ch;

  always_comb begin
    if (int'(width) > MAX_FIELD) begin
      width_sat = CW'(MAX_FIELD);
    end else begin
      width_sat = CW'(width);
    end
    if (precision[PREC_W-1]) begin
      prec_sat = '0;
    end else if (int'(precision[PREC_W-2:0]) > MAX_FIELD) begin
      prec_sat = CW'(MAX_FIELD);
    end else begin
      prec_sat = CW'(precision[PREC_W-2:0]);
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= BCD_ADJ_MIN) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + BCD_ADJ;
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_comb begin
    hi = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
        hi = ND_W'(i + 1);
      end
    end
    if (hi == '0) begin
      nd_c = (has_prec && prec_s == '0) ? ND_W'(0) : ND_W'(1);
    end else begin
      nd_c = hi;
    end
    len_c  = (CW'(nd_c) < prec_s) ? prec_s : CW'(nd_c);
    body_c = len_c + CW'(add);
    pad_c  = (width_s > body_c) ? (width_s - body_c) : '0;
  end

  assign add = neg || fplus || fspace;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg      <= value[VALUE_W-1];
      mag      <= value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value)) : VALUE_W'(value);
      bcd      <= '0;
      bit_cnt  <= '0;
      width_s  <= width_sat;
      prec_s   <= prec_sat;
      has_prec <= !precision[PREC_W-1];
      fminus   <= flag_minus;
      fzero    <= flag_zero;
      fplus    <= flag_plus;
      fspace   <= flag_space;
    end else if (cmd.conv) begin
      bcd     <= {bcd_adj[NUM_DIGITS*DIGIT_W-2:0], mag[VALUE_W-1]};
      mag     <= {mag[VALUE_W-2:0], 1'b0};
      bit_cnt <= bit_cnt + BIT_CNT_W'(1);
    end
    if (cmd.size) begin
      nd <= nd_c;
      if (!has_prec && fzero && !fminus) begin
        len <= len_c + pad_c;
        pad <= '0;
      end else begin
        len <= len_c;
        pad <= pad_c;
      end
    end
    if (cmd.cnt_load) begin
      cnt <= (cmd.cnt_sel == CNT_LEN) ? len : pad;
    end else if (cmd.cnt_dec) begin
      cnt <= cnt - CW'(1);
    end
  end

  assign pos = cnt - CW'(1);

  always_comb begin
    digit = '0;
    if (pos < CW'(nd)) begin
      digit = bcd[pos[ND_W-1:0]*DIGIT_W +: DIGIT_W];
    end
  end

  always_comb begin
    if (neg) begin
      sign_ch = CH_MINUS;
    end else if (fplus) begin
      sign_ch = CH_PLUS;
    end else begin
      sign_ch = CH_SPACE;
    end
    unique case (cmd.char_sel)
      SEL_SPACE: char_c = CH_SPACE;
      SEL_SIGN:  char_c = sign_ch;
      SEL_DIGIT: char_c = CH_ZERO + CHAR_W'(digit);
      default:   char_c = CH_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.push) begin
      text_char <= char_c;
      last      <= cmd.last;
    end
  end

  assign sts.conv_done = (bit_cnt == BIT_CNT_W'(VALUE_W - 1));
  assign sts.cnt_one   = (cnt == CW'(1));
  assign sts.lpad_en   = !fminus && (pad != '0);
  assign sts.sign_en   = add;
  assign sts.body_en   = (len != '0);
  assign sts.rpad_en   = fminus && (pad != '0);
  assign sts.out_free  = !out_valid || out_ready;

endmodule

[src/signed_decimal_field_formatter.sv]
// Channel  Role    Payload
// num      sink    value, width, precision, flag_minus, flag_zero, flag_plus, flag_space
// text     source  text_char, last
//
// Each item yields N characters (0 to MAX_FIELD + 1). The sequencer takes the transfer,
// runs the bit-serial binary-to-BCD conversion over all 32 bits, sizes the field in the
// size and start states, then pushes one character per cycle while the output register is free.
// A new item is taken only once the previous one has pushed its last character.
// Reset is synchronous and clears the sequencer and the output valid.
// While text.ready is low, the pending character holds and the sequencer waits.
module signed_decimal_field_formatter import sdff_pkg::*; #(
  parameter int MAX_FIELD = 63
) (
  input logic        clk,
  input logic        rst,
  sdff_num_if.sink   num,
  sdff_text_if.source text
);

  sdff_cmd_t cmd;
  sdff_sts_t sts;

  sdff_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (num.valid),
    .in_ready (num.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sdff_dp #(
    .MAX_FIELD (MAX_FIELD)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .value      (num.value),
    .width      (num.width),
    .precision  (num.precision),
    .flag_minus (num.flag_minus),
    .flag_zero  (num.flag_zero),
    .flag_plus  (num.flag_plus),
    .flag_space (num.flag_space),
    .out_ready  (text.ready),
    .out_valid  (text.valid),
    .text_char  (text.text_char),
    .last       (text.last)
  );

endmodule

[src/sdff_chk.sv]
module sdff_chk import sdff_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              num_valid,
  input logic              num_ready,
  input logic              text_valid,
  input logic              text_ready,
  input logic [CHAR_W-1:0] text_char,
  input logic              text_last
);

  assert property (@(posedge clk) rst |=> !text_valid)
    else $error("text valid after reset");

  assert property (@(posedge clk) disable iff (rst)
    (num_valid && num_ready) |=> !num_ready)
    else $error("input taken again before the item was formatted");

  assert property (@(posedge clk) disable iff (rst)
    (text_valid && text_ready && !text_last) |-> !num_ready)
    else $error("input ready in the middle of an item");

  assert property (@(posedge clk) disable iff (rst)
    (text_valid && !text_ready) |=> text_valid)
    else $error("text valid dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    (text_valid && !text_ready) |=> ($stable(text_char) && $stable(text_last)))
    else $error("text payload changed while stalled");

endmodule

bind signed_decimal_field_formatter sdff_chk u_sdff_chk (
  .clk        (clk),
  .rst        (rst),
  .num_valid  (num.valid),
  .num_ready  (num.ready),
  .text_valid (text.valid),
  .text_ready (text.ready),
  .text_char  (text.text_char),
  .text_last  (text.last)
);

[tb/sv/decimal_text_checker.sv]
`timescale 1ns / 1ps

module decimal_text_checker import sdff_pkg::*; (
  input  logic clk,
  input  logic rst,
  sdff_num_if  num,
  sdff_text_if text,
  output int   mismatches,
  output int   outstanding
);

  localparam int RADIX = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_beat_t;

  text_beat_t expected_chars[$];
  int         fail_tally = 0;

  assign mismatches = fail_tally;

  // Appends the characters of one formatted field to the expected stream.
  function automatic void format_decimal(
    input logic signed [VALUE_W-1:0] value,
    input logic [WIDTH_W-1:0]        width,
    input logic signed [PREC_W-1:0]  precision,
    input logic                      f_minus,
    input logic                      f_zero,
    input logic                      f_plus,
    input logic                      f_space
  );
    logic [VALUE_W-1:0] mag;
    logic [DIGIT_W-1:0] digits[NUM_DIGITS];
    logic [CHAR_W-1:0]  sign_ch;
    logic [CHAR_W-1:0]  field[$];
    logic               has_prec;
    int                 n_digits;
    int                 prec;
    int                 len;
    int                 sign_len;
    int                 pad;
    text_beat_t         beat;

    has_prec = !precision[PREC_W-1];
    prec     = has_prec ? int'(precision) : 0;
    mag      = value;
    if (value < 0) begin
      mag = ~mag + 1'b1;
    end

    n_digits = 0;
    if (!(mag == 0 && has_prec && prec == 0)) begin
      do begin
        digits[n_digits] = DIGIT_W'(mag % RADIX);
        mag              = mag / RADIX;
        n_digits++;
      end while (mag != 0);
    end

    len      = (n_digits < prec) ? prec : n_digits;
    sign_len = 1;
    sign_ch  = CH_SPACE;
    if (value < 0) begin
      sign_ch = CH_MINUS;
    end else if (f_plus) begin
      sign_ch = CH_PLUS;
    end else if (f_space) begin
      sign_ch = CH_SPACE;
    end else begin
      sign_len = 0;
    end

    pad = (int'(width) > len + sign_len) ? int'(width) - len - sign_len : 0;
    if (!has_prec && f_zero && !f_minus) begin
      len = len + pad;
      pad = 0;
    end

    if (!f_minus) begin
      repeat (pad) field.push_back(CH_SPACE);
    end
    if (sign_len != 0) begin
      field.push_back(sign_ch);
    end
    for (int i = len - 1; i >= 0; i--) begin
      field.push_back((i < n_digits) ? CH_ZERO + CHAR_W'(digits[i]) : CH_ZERO);
    end
    if (f_minus) begin
      repeat (pad) field.push_back(CH_SPACE);
    end

    foreach (field[i]) begin
      beat.ch   = field[i];
      beat.last = (i == field.size() - 1);
      expected_chars.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin
    text_beat_t want;
    if (rst) begin
      expected_chars.delete();
    end else begin
      if (text.valid && text.ready) begin
        if (expected_chars.size() == 0) begin
          fail_tally++;
          $display("%0t: unexpected transfer, expected none, actual char %h last %b",
                   $time, text.text_char, text.last);
        end else begin
          want = expected_chars.pop_front();
          if (text.text_char !== want.ch) begin
            fail_tally++;
            $display("%0t: text_char mismatch, expected %h, actual %h",
                     $time, want.ch, text.text_char);
          end
          if (text.last !== want.last) begin
            fail_tally++;
            $display("%0t: last mismatch, expected %b, actual %b",
                     $time, want.last, text.last);
          end
        end
      end
      if (num.valid && num.ready) begin
        format_decimal(num.value, num.width, num.precision, num.flag_minus,
                       num.flag_zero, num.flag_plus, num.flag_space);
      end
    end
    outstanding <= expected_chars.size();
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench import sdff_pkg::*;;

  localparam int RESET_CYCLES  = 12;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 150;
  localparam int RANDOM_ITEMS  = 240;

  localparam logic signed [VALUE_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

  // Flag bundles are {minus, zero, plus, space}.
  localparam logic [3:0] NO_FLAGS = 4'b0000;
  localparam logic [3:0] F_MINUS  = 4'b1000;
  localparam logic [3:0] F_ZERO   = 4'b0100;
  localparam logic [3:0] F_PLUS   = 4'b0010;
  localparam logic [3:0] F_SPACE  = 4'b0001;
  localparam int         NO_PREC  = -1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches;
  int   outstanding;
  bit   hold_text_req = 1'b0;

  sdff_num_if  num ();
  sdff_text_if text ();

  signed_decimal_field_formatter #(.MAX_FIELD(63)) DUT (
    .clk  (clk),
    .rst  (rst),
    .num  (num),
    .text (text)
  );

  decimal_text_checker text_check (
    .clk         (clk),
    .rst         (rst),
    .num         (num),
    .text        (text),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #10 clk = ~clk;

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return $urandom_range(0, 1) ? INT_MIN : INT_MAX;
      1: return $urandom_range(0, 1) ? 0 : -1;
      2: return int'($urandom_range(0, 9)) * ($urandom_range(0, 1) ? 1 : -1);
      3, 4: return int'($urandom_range(0, 99999)) * ($urandom_range(0, 1) ? 1 : -1);
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_width();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(0, 12);
    if (r < 9) return $urandom_range(13, 30);
    return $urandom_range(31, 63);
  endfunction

  function automatic int pick_precision();
    int r;
    r = $urandom_range(0, 19);
    if (r < 6) return -int'($urandom_range(1, 64));
    if (r < 9) return 0;
    if (r < 18) return $urandom_range(1, 12);
    return $urandom_range(13, 63);
  endfunction

  task automatic send_number(input logic signed [VALUE_W-1:0] value, input int width,
                             input int precision, input logic [3:0] flags);
    num.value      <= value;
    num.width      <= WIDTH_W'(width);
    num.precision  <= PREC_W'(precision);
    {num.flag_minus, num.flag_zero, num.flag_plus, num.flag_space} <= flags;
    num.valid      <= 1'b1;
    do @(posedge clk); while (!num.ready);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      num.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_for_text_drain();
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    #80_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int hold_left;
    int free_left;
    int gap;
    bit hold_taken;
    hold_left  = 0;
    free_left  = 0;
    hold_taken = 1'b0;
    text.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        text.ready <= 1'b0;
      end else if (hold_left > 0) begin
        text.ready <= 1'b0;
        hold_left--;
      end else if (hold_text_req && !hold_taken) begin
        hold_taken  = 1'b1;
        hold_left   = HOLD_CYCLES - 1;
        text.ready <= 1'b0;
      end else if (free_left > 0) begin
        text.ready <= 1'b1;
        free_left--;
      end else if ($urandom_range(0, 9) == 0) begin
        free_left   = $urandom_range(20, 100);
        text.ready <= 1'b1;
      end else begin
        gap = idle_length();
        if (gap > 0) begin
          hold_left   = gap - 1;
          text.ready <= 1'b0;
        end else begin
          text.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    num.valid      <= 1'b0;
    num.value      <= '0;
    num.width      <= '0;
    num.precision  <= '0;
    num.flag_minus <= 1'b0;
    num.flag_zero  <= 1'b0;
    num.flag_plus  <= 1'b0;
    num.flag_space <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    send_number(0, 0, 0, NO_FLAGS);                  idle_sender(idle_length());
    send_number(0, 0, 0, F_PLUS);                    idle_sender(idle_length());
    send_number(0, 5, 0, NO_FLAGS);                  idle_sender(idle_length());
    send_number(0, 6, 0, F_MINUS | F_SPACE);         idle_sender(idle_length());
    send_number(0, 0, NO_PREC, NO_FLAGS);            idle_sender(idle_length());
    send_number(INT_MIN, 0, NO_PREC, NO_FLAGS);      idle_sender(idle_length());
    send_number(INT_MIN, 30, 20, F_MINUS);           idle_sender(idle_length());
    send_number(INT_MAX, 0, NO_PREC, F_PLUS);        idle_sender(idle_length());
    send_number(INT_MAX, 63, NO_PREC, F_ZERO);       idle_sender(idle_length());
    send_number(-1, 10, NO_PREC, F_ZERO);            idle_sender(idle_length());
    send_number(42, 10, 5, F_ZERO);                  idle_sender(idle_length());
    send_number(42, 8, NO_PREC, F_MINUS | F_ZERO);   idle_sender(idle_length());
    send_number(7, 0, NO_PREC, F_PLUS | F_SPACE);    idle_sender(idle_length());
    send_number(7, 4, NO_PREC, F_SPACE);             idle_sender(idle_length());
    send_number(1, 63, NO_PREC, NO_FLAGS);           idle_sender(idle_length());
    send_number(-5, 0, 63, NO_FLAGS);                idle_sender(idle_length());
    send_number(5, 63, 63, F_PLUS);                  idle_sender(idle_length());
    send_number(123, 0, -64, F_ZERO);                idle_sender(idle_length());
    send_number(123, 12, -64, F_ZERO | F_SPACE);     idle_sender(idle_length());
    send_number(0, 63, 0, F_MINUS);                  idle_sender(idle_length());
    send_number(98765, 3, 2, NO_FLAGS);              idle_sender(idle_length());
    send_number(-2147483647, 15, NO_PREC, F_PLUS);   idle_sender(idle_length());
    send_number(0, 1, 0, F_ZERO);
    num.valid <= 1'b0;
    wait_for_text_drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 80) begin
        hold_text_req = 1'b1;
      end
      if (i == 160) begin
        num.valid <= 1'b0;
        wait_for_text_drain();
      end
      send_number(pick_value(), pick_width(), pick_precision(), 4'($urandom_range(0, 15)));
      if ((i / 20) % 3 != 1) begin
        idle_sender(idle_length());
      end
    end

    num.valid <= 1'b0;
    wait_for_text_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
